### hdl/positional_circular_list_assert.svh
// assertion macros shared by the positional list checker
`ifndef POSITIONAL_CIRCULAR_LIST_ASSERT_SVH
`define POSITIONAL_CIRCULAR_LIST_ASSERT_SVH

// clocked assertion, masked while reset is held
`define PCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("positional list check failed");

// clocked assertion that also holds during reset
`define PCL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("positional list reset check failed");

`endif

### hdl/pcl_pkg.sv
// package: codes, defaults and cell control type for the positional list
`timescale 1ns / 1ps
`default_nettype none
package pcl_pkg;

  // default list depth
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_HD  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_TL  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_POS = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_HD  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_TL  = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_POS = 3'd6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // per-cell load selects, highest priority first
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
    logic take_head;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hdl/pcl_cell.sv
// one list cell: holds an entry and loads from a neighbour, the head or a new value
`timescale 1ns / 1ps
`default_nettype none
module pcl_cell
  import pcl_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [VAL_W-1:0] new_val,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic [VAL_W-1:0] head_val,
  output logic      [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // select the source for this cycle
  always_comb begin
    if (ctl.take_new) begin
      val_nxt = new_val;
    end else if (ctl.take_left) begin
      val_nxt = left_val;
    end else if (ctl.take_right) begin
      val_nxt = right_val;
    end else if (ctl.take_head) begin
      val_nxt = head_val;
    end else begin
      val_nxt = val_r;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

### hdl/positional_circular_list.sv
// Positional list: each edit gives one status word, registered and shown in the cycle after it is taken.
// A readout of n entries gives n words: one word a cycle while the output is not stalled,
// while the cell row rotates by one place; an empty list gives one status word.
// One operation at a time; the next word is taken once the last result is loaded and the output is free.
// Synchronous active-low reset empties the list; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module positional_circular_list
  import pcl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value [31:0], position [36:32], zero pad
  input  wire logic [2:0]  in_tuser,   // op [2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // data_out [31:0]
  output logic      [1:0]  out_tuser,  // status [1:0]
  output logic             out_tlast   // last_result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // input fields
  logic [OP_W-1:0]  in_op;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  assign in_op    = in_tuser;
  assign in_value = in_tdata[VAL_W-1:0];
  assign in_pos   = in_tdata[VAL_W+POS_W-1:VAL_W];

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [VAL_W-1:0] odata_r, odata_nxt;
  logic [ST_W-1:0]  ostat_r, ostat_nxt;
  logic             olast_r, olast_nxt;

  logic             out_free;
  logic             in_acc;
  logic             ins, del, rot;
  logic [CW-1:0]    idx;
  logic [PW-1:0]    pos_e, cnt_e;
  logic [CW-1:0]    pos_m1;
  cell_ctl_t        ctl  [DEPTH];
  logic [VAL_W-1:0] vals [DEPTH];

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign pos_e     = PW'(in_pos);
  assign cnt_e     = PW'(count_r);
  assign pos_m1    = CW'(pos_e - PW'(1));

  // operation decode and sequencing
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    ostat_nxt  = ostat_r;
    olast_nxt  = olast_r;
    ins        = 1'b0;
    del        = 1'b0;
    rot        = 1'b0;
    idx        = '0;
    if (state_r == ST_IDLE) begin
      if (in_acc) begin
        odata_nxt = '0;
        olast_nxt = 1'b1;
        ostat_nxt = ST_OK;
        case (in_op)
          OP_READ: begin
            if (count_r == '0) begin
              ostat_nxt  = ST_EMPTY;
              ovalid_nxt = 1'b1;
            end else begin
              state_nxt = ST_READ;
              rem_nxt   = count_r;
            end
          end
          OP_ADD_HD, OP_ADD_TL, OP_ADD_POS: begin
            ovalid_nxt = 1'b1;
            if (cnt_e >= PW'(DEPTH)) begin
              ostat_nxt = ST_FULL;
            end else if (in_op == OP_ADD_HD) begin
              ins = 1'b1;
            end else if (in_op == OP_ADD_TL) begin
              ins = 1'b1;
              idx = count_r;
            end else if (pos_e == '0 || pos_e > cnt_e + PW'(1)) begin
              ostat_nxt = ST_BADPOS;
            end else begin
              ins = 1'b1;
              idx = pos_m1;
            end
            if (ins) begin
              count_nxt = count_r + CW'(1);
            end
          end
          OP_DEL_HD, OP_DEL_TL, OP_DEL_POS: begin
            ovalid_nxt = 1'b1;
            if (count_r == '0) begin
              ostat_nxt = ST_EMPTY;
            end else if (in_op == OP_DEL_HD) begin
              del = 1'b1;
            end else if (in_op == OP_DEL_TL) begin
              del = 1'b1;
              idx = count_r - CW'(1);
            end else if (pos_e == '0 || pos_e > cnt_e) begin
              ostat_nxt = ST_BADPOS;
            end else begin
              del = 1'b1;
              idx = pos_m1;
            end
            if (del) begin
              count_nxt = count_r - CW'(1);
            end
          end
          default: begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_BADPOS;
          end
        endcase
      end
    end else begin
      // readout: emit the head and rotate the occupied cells by one place
      if (out_free) begin
        rot        = 1'b1;
        ovalid_nxt = 1'b1;
        odata_nxt  = vals[0];
        ostat_nxt  = ST_OK;
        olast_nxt  = (rem_r == CW'(1));
        rem_nxt    = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  // per-cell selects
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].take_new   = ins && (CW'(i) == idx);
      ctl[i].take_left  = ins && (CW'(i) > idx);
      ctl[i].take_right = (del && (CW'(i) >= idx)) ||
                          (rot && (CW'(i) < count_r - CW'(1)));
      ctl[i].take_head  = rot && (CW'(i) == count_r - CW'(1));
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pcl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[g]),
      .new_val   (in_value),
      .left_val  ((g == 0) ? vals[0] : vals[(g == 0) ? 0 : g - 1]),
      .right_val ((g == DEPTH - 1) ? vals[DEPTH-1] : vals[(g == DEPTH - 1) ? g : g + 1]),
      .head_val  (vals[0]),
      .val       (vals[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rem_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

### hdl/pcl_checker.sv
// port-level checks for the positional list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "positional_circular_list_assert.svh"
module pcl_checker
  import pcl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  logic in_word;
  assign in_word = in_tvalid && in_tready && (in_tdata[39:37] == 3'd0 || in_tuser != '0);

  // a stalled result word holds
  `PCL_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // only readout entries continue a run, and those are always ok
  `PCL_ASSERT(a_run_ok, out_tvalid && !out_tlast |-> out_tuser == ST_OK)

  // status words carry zero data
  `PCL_ASSERT(a_stat_zero, out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)

  // no word taken while a result is stalled
  `PCL_ASSERT(a_no_take_stall, out_tvalid && !out_tready |-> !(in_word && in_tready))

  // reset leaves the output empty
  `PCL_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid)

endmodule

bind positional_circular_list pcl_checker u_pcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### dv/positional_circular_list_tb.sv
// self-checking testbench for the positional list: directed edge cases then random traffic
`timescale 1ns / 1ps
`default_nettype none
module positional_circular_list_tb;
  import pcl_pkg::*;

  // op code with no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int IDLE_MAX = 13;

  typedef struct {
    logic [VAL_W-1:0] data;
    logic [ST_W-1:0]  status;
    logic             is_last;
  } list_word_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [39:0]      in_tdata   = '0;
  logic [2:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;

  // mirror of the list contents and length
  logic [VAL_W-1:0] list_model [DEPTH_DEF];
  int               list_len = 0;
  list_word_t       expected_words [$];

  int               err_cnt    = 0;
  int               stall_left = 0;
  bit               idle_on    = 1'b1;

  positional_circular_list #(.DEPTH(DEPTH_DEF)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("%0t  %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_word(input logic [VAL_W-1:0] data, input logic [ST_W-1:0] st,
                           input logic is_last);
    list_word_t w;
    w.data    = data;
    w.status  = st;
    w.is_last = is_last;
    expected_words.push_back(w);
  endtask

  // apply one accepted operation to the mirror and queue the words it gives
  task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    int idx;
    int k;
    case (op)
      OP_READ: begin
        if (list_len == 0) begin
          push_word('0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < list_len; k++)
            push_word(list_model[k], ST_OK, k == list_len - 1);
        end
      end
      OP_ADD_HD, OP_ADD_TL, OP_ADD_POS: begin
        // fullness wins over a bad position
        if (list_len >= DEPTH_DEF) begin
          push_word('0, ST_FULL, 1'b1);
        end else if (op == OP_ADD_POS && (pos == 0 || int'(pos) > list_len + 1)) begin
          push_word('0, ST_BADPOS, 1'b1);
        end else begin
          idx = (op == OP_ADD_HD) ? 0 : (op == OP_ADD_TL) ? list_len : int'(pos) - 1;
          for (k = list_len; k > idx; k--)
            list_model[k] = list_model[k-1];
          list_model[idx] = val;
          list_len++;
          push_word('0, ST_OK, 1'b1);
        end
      end
      OP_DEL_HD, OP_DEL_TL, OP_DEL_POS: begin
        if (list_len == 0) begin
          push_word('0, ST_EMPTY, 1'b1);
        end else if (op == OP_DEL_POS && (pos == 0 || int'(pos) > list_len)) begin
          push_word('0, ST_BADPOS, 1'b1);
        end else begin
          idx = (op == OP_DEL_HD) ? 0 : (op == OP_DEL_TL) ? list_len - 1 : int'(pos) - 1;
          for (k = idx; k + 1 < list_len; k++)
            list_model[k] = list_model[k+1];
          list_len--;
          push_word('0, ST_OK, 1'b1);
        end
      end
      default: push_word('0, ST_BADPOS, 1'b1);
    endcase
  endtask

  // send one word, optionally after a random gap, and predict on acceptance
  task automatic send_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, pos, val};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    apply_list_op(op, val, pos);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    list_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      stall_left = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (expected_words.size() == 0) begin
        report_error($sformatf("unexpected word data=%h status=%0d last=%0b",
                               out_tdata, out_tuser, out_tlast));
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.data)
          report_error($sformatf("data mismatch: got %h want %h", out_tdata, want.data));
        if (out_tuser !== want.status)
          report_error($sformatf("status mismatch: got %0d want %0d",
                                 out_tuser, want.status));
        if (out_tlast !== want.is_last)
          report_error($sformatf("last mismatch: got %0b want %0b",
                                 out_tlast, want.is_last));
      end
    end
  end

  // reads, deletes, bad-position inserts and an unused op code on an empty list
  task automatic test_empty_list();
    send_word(OP_READ, 32'h0, 5'd0);
    send_word(OP_DEL_HD, 32'h0, 5'd1);
    send_word(OP_DEL_TL, 32'h0, 5'd1);
    send_word(OP_DEL_POS, 32'h0, 5'd1);
    send_word(OP_ADD_POS, 32'h1234_5678, 5'd0);
    send_word(OP_ADD_POS, 32'h1234_5678, 5'd2);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
  endtask

  // edits at head, tail and positions, including the tail position
  task automatic test_edits();
    send_word(OP_ADD_POS, 32'h0000_0001, 5'd1);
    send_word(OP_ADD_HD, 32'h8000_0000, 5'd0);
    send_word(OP_ADD_TL, 32'h7FFF_FFFF, 5'd0);
    send_word(OP_ADD_POS, 32'hFFFF_FFFF, 5'd2);
    send_word(OP_ADD_POS, 32'h0000_0000, 5'd5);
    send_word(OP_ADD_POS, 32'hDEAD_BEEF, 5'd7);
    send_word(OP_READ, 32'h0, 5'd0);
    send_word(OP_DEL_POS, 32'h0, 5'd5);
    send_word(OP_DEL_POS, 32'h0, 5'd0);
    send_word(OP_DEL_POS, 32'h0, 5'd5);
    send_word(OP_DEL_POS, 32'h0, 5'd2);
    send_word(OP_DEL_HD, 32'h0, 5'd0);
    send_word(OP_READ, 32'h0, 5'd0);
    send_word(OP_DEL_TL, 32'h0, 5'd0);
    send_word(OP_READ, 32'h0, 5'd0);
  endtask

  // fill to capacity, then inserts must report full before position checks
  task automatic test_full_list();
    while (list_len < DEPTH_DEF)
      send_word(OP_ADD_TL, $urandom, 5'($urandom));
    send_word(OP_ADD_HD, 32'h5555_5555, 5'd0);
    send_word(OP_ADD_TL, 32'hAAAA_AAAA, 5'd0);
    send_word(OP_ADD_POS, 32'h1111_1111, 5'd31);
    send_word(OP_READ, 32'h0, 5'd0);
    send_word(OP_DEL_POS, 32'h0, 5'd17);
    send_word(OP_DEL_POS, 32'h0, 5'd16);
    send_word(OP_ADD_POS, 32'h2222_2222, 5'd16);
    send_word(OP_DEL_POS, 32'h0, 5'd31);
    send_word(OP_READ, 32'h0, 5'd0);
  endtask

  // random traffic that swings the list between empty and full
  task automatic test_random(input int n_items);
    int i;
    int r;
    bit fill_mode;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    fill_mode = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (i % 10 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if (list_len == DEPTH_DEF)
        fill_mode = 1'b0;
      else if (list_len == 0)
        fill_mode = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 14)
        op = OP_READ;
      else if (r < 17)
        op = OP_UNUSED;
      else if ($urandom_range(0, 99) < (fill_mode ? 75 : 25))
        op = OP_ADD_HD + 3'($urandom_range(0, 2));
      else
        op = OP_DEL_HD + 3'($urandom_range(0, 2));
      // mostly in-range positions, sometimes anything the field holds
      if ($urandom_range(0, 4) == 0)
        pos = 5'($urandom_range(0, 31));
      else if (op == OP_ADD_POS)
        pos = 5'($urandom_range(1, list_len + 1));
      else
        pos = 5'($urandom_range(1, (list_len > 0) ? list_len : 1));
      case ($urandom_range(0, 19))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0000_0000;
        default: val = $urandom;
      endcase
      send_word(op, val, pos);
    end
    idle_on = 1'b1;
  endtask

  // sequence of tests and end of run
  initial begin
    int guard;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_edits();
    test_full_list();
    test_random(54);
    @(negedge clk);
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0)
      report_error($sformatf("%0d predicted words never arrived", expected_words.size()));
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/pcl_pkg.sv
hdl/pcl_cell.sv
hdl/positional_circular_list.sv
hdl/pcl_checker.sv
dv/positional_circular_list_tb.sv
